// ===== hw/rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== hw/rtl/mntt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mntt_pkg;
   localparam int Points = 256;
   localparam int IdxW = 8;
   localparam logic [30:0] ModP = 31'h7FFFFFFF;
   localparam logic [30:0] RootSqrtI = 31'd32768;

   typedef enum logic [1:0] {CMD_LOAD = 2'd0, CMD_RUN = 2'd1, CMD_READ = 2'd2,
                             CMD_NONE = 2'd3} cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  word_index;
      logic [30:0] word_value;
   } req_type;

   typedef struct packed {
      logic [30:0] read_value;
      logic        run_done;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic        wr_en;      // host write
      logic [7:0]  addr;
      logic [30:0] wdata;
      logic        rd_en;      // host read
      logic        bf_rd;      // butterfly read: latch element k
      logic [1:0]  bf_k;
      logic        bf_wr;      // butterfly write element k
      logic [1:0]  mode;       // 0 twist fwd, 1 dif, 2 dit, 3 twist inv
      logic [5:0]  widx;       // twiddle selector
      logic        calc;       // start compute step
      logic [2:0]  step;
   } dp_cmd_type;

   typedef struct packed {
      logic [30:0] rdata;
   } dp_sts_type;

   localparam logic [1:0] MD_TWF = 2'd0;
   localparam logic [1:0] MD_DIF = 2'd1;
   localparam logic [1:0] MD_DIT = 2'd2;
   localparam logic [1:0] MD_TWI = 2'd3;

   localparam logic [30:0] ROOT512 [126] = '{
 31'd430821412, 31'd1152650470, 31'd236104903, 31'd1577470940, 31'd485600145, 31'd224958826,
 31'd206059115, 31'd1935040570, 31'd660017901, 31'd1340846354, 31'd1896945393, 31'd2098580229,
 31'd735494074, 31'd1494204761, 31'd1641940819, 31'd26164677, 31'd1777644782, 31'd1383853684,
 31'd1093071961, 31'd648593218, 31'd1920912571, 31'd914097328, 31'd1742797653, 31'd2140339328,
 31'd1371669334, 31'd2103108137, 31'd1260750973, 31'd1362440376, 31'd1336950523, 31'd839591040,
 31'd1241207368, 31'd1179735656, 31'd1202912605, 31'd1980032781, 31'd1921627098, 31'd1668363411,
 31'd165851886, 31'd1674906685, 31'd228509164, 31'd14530030, 31'd1792244284, 31'd36557796,
 31'd1014093253, 31'd2137011181, 31'd252929270, 31'd1353673049, 31'd194696271, 31'd567259857,
 31'd853979252, 31'd1113159341, 31'd1563928157, 31'd849605071, 31'd472916039, 31'd952794586,
 31'd1309288441, 31'd373229752, 31'd528066207, 31'd951582730, 31'd141956360, 31'd1977033713,
 31'd605970061, 31'd1530121874, 31'd1556715293, 31'd978592373, 31'd378535762, 31'd1207781610,
 31'd477953613, 31'd2022380190, 31'd1398069297, 31'd1397384897, 31'd408478793, 31'd262191051,
 31'd1326503162, 31'd1362518885, 31'd1276547035, 31'd1514613395, 31'd328267072, 31'd484667533,
 31'd1133522282, 31'd280947147, 31'd1730666434, 31'd2110668387, 31'd81378258, 31'd1357626641,
 31'd655387905, 31'd1395419301, 31'd1038945916, 31'd134155457, 31'd1603661239, 31'd1398285837,
 31'd1949783546, 31'd1067683608, 31'd1916124599, 31'd187158958, 31'd1415090252, 31'd2112881577,
 31'd834535867, 31'd222141861, 31'd1553669210, 31'd736262640, 31'd1925205788, 31'd278287463,
 31'd2079025011, 31'd2137679949, 31'd1756768506, 31'd1678097410, 31'd1506666447, 31'd445356670,
 31'd1370602608, 31'd1664948088, 31'd579625837, 31'd1690787918, 31'd1082787046, 31'd2133873350,
 31'd1895558694, 31'd636875771, 31'd1644164930, 31'd820860779, 31'd1263730590, 31'd1796741361,
 31'd578660954, 31'd152276873, 31'd2085743640, 31'd812986380, 31'd1854234209, 31'd1637799161};

   localparam logic [30:0] ROOT128 [128] = '{
 31'd1, 31'd0, 31'd0, 31'd1, 31'd32768, 31'd32768, 31'd2147450879, 31'd32768,
 31'd1556715293, 31'd978592373, 31'd1168891274, 31'd1556715293, 31'd978592373, 31'd1556715293,
 31'd590768354, 31'd978592373, 31'd1241207368, 31'd1179735656, 31'd967747991, 31'd1241207368,
 31'd2112881577, 31'd1415090252, 31'd732393395, 31'd2112881577, 31'd1415090252, 31'd2112881577,
 31'd34602070, 31'd1415090252, 31'd1179735656, 31'd1241207368, 31'd906276279, 31'd1179735656,
 31'd1641940819, 31'd26164677, 31'd2121318970, 31'd1641940819, 31'd1690787918, 31'd579625837,
 31'd1567857810, 31'd1690787918, 31'd1133522282, 31'd280947147, 31'd1866536500, 31'd1133522282,
 31'd567259857, 31'd194696271, 31'd1952787376, 31'd567259857, 31'd194696271, 31'd567259857,
 31'd1580223790, 31'd194696271, 31'd280947147, 31'd1133522282, 31'd1013961365, 31'd280947147,
 31'd579625837, 31'd1690787918, 31'd456695729, 31'd579625837, 31'd26164677, 31'd1641940819,
 31'd505542828, 31'd26164677, 31'd206059115, 31'd1935040570, 31'd212443077, 31'd206059115,
 31'd1796741361, 31'd1263730590, 31'd883753057, 31'd1796741361, 31'd408478793, 31'd262191051,
 31'd1885292596, 31'd408478793, 31'd373229752, 31'd1309288441, 31'd838195206, 31'd373229752,
 31'd228509164, 31'd14530030, 31'd2132953617, 31'd228509164, 31'd134155457, 31'd1038945916,
 31'd1108537731, 31'd134155457, 31'd2079025011, 31'd2137679949, 31'd9803698, 31'd2079025011,
 31'd2140339328, 31'd1742797653, 31'd404685994, 31'd2140339328, 31'd1742797653, 31'd2140339328,
 31'd7144319, 31'd1742797653, 31'd2137679949, 31'd2079025011, 31'd68458636, 31'd2137679949,
 31'd1038945916, 31'd134155457, 31'd2013328190, 31'd1038945916, 31'd14530030, 31'd228509164,
 31'd1918974483, 31'd14530030, 31'd1309288441, 31'd373229752, 31'd1774253895, 31'd1309288441,
 31'd262191051, 31'd408478793, 31'd1739004854, 31'd262191051, 31'd1263730590, 31'd1796741361,
 31'd350742286, 31'd1263730590, 31'd1935040570, 31'd206059115, 31'd1941424532, 31'd1935040570};

   function automatic logic [30:0] m_add(input logic [30:0] a, input logic [30:0] b);
      logic [31:0] s;
      logic [31:0] t;
      s = {1'b0, a} + {1'b0, b};
      t = {1'b0, s[30:0]} + {31'd0, s[31]};
      m_add = (t >= {1'b0, ModP}) ? 31'(t - {1'b0, ModP}) : t[30:0];
   endfunction

   function automatic logic [30:0] m_sub(input logic [30:0] a, input logic [30:0] b);
      m_sub = m_add(a, ModP - b);
   endfunction

   function automatic logic [30:0] m_red(input logic [61:0] x);
      logic [31:0] r;
      logic [31:0] q;
      r = {1'b0, x[30:0]} + {1'b0, x[61:31]};
      q = {1'b0, r[30:0]} + {31'd0, r[31]};
      m_red = (q >= {1'b0, ModP}) ? 31'(q - {1'b0, ModP}) : q[30:0];
   endfunction

   // power k of the order-512 root, k in 0..127; returns {re, im}
   function automatic logic [61:0] twist(input logic [6:0] k);
      logic [5:0] m;
      logic [6:0] lo;
      logic [6:0] hi;
      m = 6'(7'd0 - k);
      lo = {6'(k[5:0] - 6'd1), 1'b0};
      hi = {6'(m - 6'd1), 1'b0};
      if (k == 7'd0) twist = {31'd1, 31'd0};
      else if (k < 7'd64) twist = {ROOT512[lo], ROOT512[7'(lo + 7'd1)]};
      else if (k == 7'd64) twist = {RootSqrtI, RootSqrtI};
      else twist = {ROOT512[7'(hi + 7'd1)], ROOT512[hi]};
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/mntt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mntt_datapath
   import mntt_pkg::*;
(
   input  wire logic       clock,
   input  wire dp_cmd_type cmd,
   output dp_sts_type      sts
);
   logic [30:0] mem [Points];
   logic [30:0] rd_ff;
   logic [30:0] x_ff [4];
   logic [30:0] y_ff [4];
   logic [30:0] ar_ff, ai_ff, br_ff, bi_ff, wr_ff, wi_ff, w2r_ff, w2i_ff;
   logic [61:0] p_ff [4];
   logic [61:0] q_ff [4];
   logic [30:0] t_ff [4];
   logic [61:0] tw0, tw1;
   logic [30:0] cr, ci;

   assign tw0 = twist({1'b0, cmd.widx});
   assign tw1 = twist({1'b1, cmd.widx});
   assign cr = ROOT128[{cmd.widx, 1'b0}];
   assign ci = ROOT128[{cmd.widx, 1'b1}];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.bf_wr) begin
         mem[cmd.addr] <= y_ff[cmd.bf_k];
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.addr];
      end
      if (cmd.bf_rd) begin
         x_ff[cmd.bf_k] <= mem[cmd.addr];
      end
      if (cmd.calc) begin
         case (cmd.step)
            3'd0: begin  // set up complex operands a,b with twiddles w,w2
               case (cmd.mode)
                  MD_TWF: begin
                     ar_ff <= x_ff[0]; ai_ff <= x_ff[2]; br_ff <= x_ff[1]; bi_ff <= x_ff[3];
                     wr_ff <= tw0[61:31]; wi_ff <= tw0[30:0];
                     w2r_ff <= tw1[61:31]; w2i_ff <= tw1[30:0];
                  end
                  MD_DIF: begin
                     ar_ff <= x_ff[1]; ai_ff <= x_ff[3]; br_ff <= x_ff[1]; bi_ff <= x_ff[3];
                     wr_ff <= cr; wi_ff <= ci; w2r_ff <= cr; w2i_ff <= ci;
                  end
                  MD_DIT: begin
                     ar_ff <= m_sub(x_ff[0], x_ff[2]); ai_ff <= m_sub(x_ff[1], x_ff[3]);
                     br_ff <= m_sub(x_ff[0], x_ff[2]); bi_ff <= m_sub(x_ff[1], x_ff[3]);
                     wr_ff <= cr; wi_ff <= m_sub(31'd0, ci);
                     w2r_ff <= cr; w2i_ff <= m_sub(31'd0, ci);
                  end
                  default: begin
                     ar_ff <= m_add(x_ff[0], x_ff[2]); ai_ff <= m_add(x_ff[1], x_ff[3]);
                     br_ff <= m_sub(x_ff[0], x_ff[2]); bi_ff <= m_sub(x_ff[1], x_ff[3]);
                     wr_ff <= tw0[61:31]; wi_ff <= m_sub(31'd0, tw0[30:0]);
                     w2r_ff <= tw1[61:31]; w2i_ff <= m_sub(31'd0, tw1[30:0]);
                  end
               endcase
            end
            3'd1: begin
               p_ff[0] <= 62'(ar_ff) * 62'(wr_ff);
               p_ff[1] <= 62'(ai_ff) * 62'(wi_ff);
               p_ff[2] <= 62'(ar_ff) * 62'(wi_ff);
               p_ff[3] <= 62'(ai_ff) * 62'(wr_ff);
               q_ff[0] <= 62'(br_ff) * 62'(w2r_ff);
               q_ff[1] <= 62'(bi_ff) * 62'(w2i_ff);
               q_ff[2] <= 62'(br_ff) * 62'(w2i_ff);
               q_ff[3] <= 62'(bi_ff) * 62'(w2r_ff);
            end
            3'd2: begin
               t_ff[0] <= m_sub(m_red(p_ff[0]), m_red(p_ff[1]));
               t_ff[1] <= m_add(m_red(p_ff[2]), m_red(p_ff[3]));
               t_ff[2] <= m_sub(m_red(q_ff[0]), m_red(q_ff[1]));
               t_ff[3] <= m_add(m_red(q_ff[2]), m_red(q_ff[3]));
            end
            default: begin
               case (cmd.mode)
                  MD_TWF: begin
                     y_ff[0] <= m_add(t_ff[0], t_ff[2]);
                     y_ff[1] <= m_add(t_ff[1], t_ff[3]);
                     y_ff[2] <= m_sub(t_ff[0], t_ff[2]);
                     y_ff[3] <= m_sub(t_ff[1], t_ff[3]);
                  end
                  MD_DIF: begin
                     y_ff[0] <= m_add(x_ff[0], t_ff[0]);
                     y_ff[1] <= m_add(x_ff[2], t_ff[1]);
                     y_ff[2] <= m_sub(x_ff[0], t_ff[0]);
                     y_ff[3] <= m_sub(x_ff[2], t_ff[1]);
                  end
                  MD_DIT: begin
                     y_ff[0] <= m_add(x_ff[0], x_ff[2]);
                     y_ff[1] <= t_ff[0];
                     y_ff[2] <= m_add(x_ff[1], x_ff[3]);
                     y_ff[3] <= t_ff[1];
                  end
                  default: begin
                     y_ff[0] <= t_ff[0];
                     y_ff[1] <= t_ff[2];
                     y_ff[2] <= t_ff[1];
                     y_ff[3] <= t_ff[3];
                  end
               endcase
            end
         endcase
      end
   end

   assign sts.rdata = rd_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mntt_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mntt_controller
   import mntt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);
   typedef enum logic [2:0] {ST_IDLE, ST_RDWAIT, ST_FETCH, ST_CALC, ST_STORE, ST_RESP}
      state_type;

   state_type   state_ff;
   logic        inv_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [2:0]  stage_ff;   // 0 or 7 twist, 1..6 butterfly stages
   logic [5:0]  pos_ff;     // butterfly index within stage
   logic [2:0]  sub_ff;     // element or compute step
   logic [2:0]  lg;         // log2 of butterfly length
   logic [7:0]  len;
   logic [7:0]  base;
   logic [5:0]  blk;
   logic [5:0]  jj;
   logic [7:0]  elem_addr;
   logic [1:0]  mode;
   logic        accept;
   logic [1:0]  k;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // forward: stage 0 twist, stages 1..6 lengths 32..1
   // inverse: stages 1..6 lengths 1..32, stage 7 twist
   always_comb begin
      lg = inv_ff ? 3'(stage_ff - 3'd1) : 3'(3'd6 - stage_ff);
      len = 8'd1 << lg;
      blk = pos_ff >> lg;
      jj = pos_ff & 6'(len - 8'd1);
      base = 8'({blk, 2'b00} << lg) + 8'(jj);
      k = sub_ff[1:0];
      if ((!inv_ff && stage_ff == 3'd0) || (inv_ff && stage_ff == 3'd7)) begin
         mode = inv_ff ? MD_TWI : MD_TWF;
         elem_addr = {k, pos_ff};
      end else begin
         mode = inv_ff ? MD_DIT : MD_DIF;
         elem_addr = 8'(base + 8'(len * 8'(k)));
      end
   end

   always_comb begin
      cmd = '0;
      cmd.addr = req_data.word_index;
      cmd.wdata = (req_data.word_value == ModP) ? 31'd0 : req_data.word_value;
      cmd.mode = mode;
      cmd.widx = ((mode == MD_TWF) || (mode == MD_TWI)) ? pos_ff : blk;
      cmd.bf_k = k;
      cmd.step = sub_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.wr_en = accept && (req_data.cmd == CMD_LOAD);
            cmd.rd_en = accept && (req_data.cmd == CMD_READ);
         end
         ST_FETCH: begin
            cmd.addr = elem_addr;
            cmd.bf_rd = 1'b1;
         end
         ST_CALC: cmd.calc = 1'b1;
         ST_STORE: begin
            cmd.addr = elem_addr;
            cmd.bf_wr = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stage_ff <= '0;
         pos_ff <= '0;
         sub_ff <= '0;
      end else begin
         if (csr_we) begin
            inv_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_ff <= '0;
                  case (req_data.cmd)
                     CMD_READ: state_ff <= ST_RDWAIT;
                     CMD_RUN: begin
                        state_ff <= ST_FETCH;
                        stage_ff <= inv_ff ? 3'd1 : 3'd0;
                        pos_ff <= '0;
                        sub_ff <= '0;
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_RDWAIT: begin
               rsp_ff.read_value <= sts.rdata;
               rsp_ff.run_done <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_FETCH: begin
               sub_ff <= 3'(sub_ff + 3'd1);
               if (sub_ff == 3'd3) begin
                  sub_ff <= '0;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               sub_ff <= 3'(sub_ff + 3'd1);
               if (sub_ff == 3'd3) begin
                  sub_ff <= '0;
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: begin
               sub_ff <= 3'(sub_ff + 3'd1);
               if (sub_ff == 3'd3) begin
                  sub_ff <= '0;
                  pos_ff <= 6'(pos_ff + 6'd1);
                  state_ff <= ST_FETCH;
                  if (pos_ff == 6'd63) begin
                     if ((inv_ff && stage_ff == 3'd7) || (!inv_ff && stage_ff == 3'd6)) begin
                        state_ff <= ST_RESP;
                     end
                     stage_ff <= 3'(stage_ff + 3'd1);
                  end
               end
            end
            default: begin
               rsp_ff.read_value <= '0;
               rsp_ff.run_done <= 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mersenne_ntt_256_engine.sv =====
// Negacyclic NTT engine over residues modulo 2^31-1, 256-word store.
// Request channel req_valid/req_ready/req_data: cmd LOAD writes one word,
// READ returns one word, RUN transforms the whole store in place.
// Response channel rsp_valid/rsp_ready/rsp_data: one response per request;
// read_value for READ, run_done for RUN.
// csr_we/csr_wdata sets the direction: 0 forward, 1 inverse (unscaled).
// LOAD and unused commands answer straight from idle; READ passes through a read wait state.
// RUN: 7 passes of 64 butterflies, each made of 4 fetches and 4
// writes on the single store port and 4 arithmetic steps, then a
// done state sends the response. One request is in flight at a time.
// A stalled response holds; the next request is taken in the cycle the
// response is accepted. Reset clears control and the direction bit; the
// store keeps no defined contents until loaded.
`timescale 1ns / 1ps
`default_nettype none
module mersenne_ntt_256_engine
   import mntt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   mntt_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_wdata, .cmd, .sts
   );

   mntt_datapath u_dp (.clock, .cmd, .sts);
endmodule
`default_nettype wire

// ===== hw/rtl/mntt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mntt_checker
   import mntt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   `CHK_IMPL(a_done_zero, clock, reset, rsp_valid && rsp_data.run_done, rsp_data.read_value == '0)
   `CHK_IMPL(a_canon, clock, reset, rsp_valid, rsp_data.read_value != ModP)
   `CHK_NEXT(a_one_out, clock, reset, req_valid && req_ready, !req_ready || rsp_valid)
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule
bind mersenne_ntt_256_engine mntt_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire
